@@ rtl/core/cosine_anomaly_score_assert.svh @@
// Assertion macros shared by the cosine anomaly score RTL
`ifndef COSINE_ANOMALY_SCORE_ASSERT_SVH
`define COSINE_ANOMALY_SCORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define CAS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define CAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/cas_pkg.sv @@
// Package with types and constants of the cosine anomaly score block
`timescale 1ns / 1ps

package cas_pkg;

    localparam int ELEM_W      = 16;   // Q4.12 element
    localparam int DOT_W       = 42;   // dot product accumulator
    localparam int ENERGY_W    = 41;   // sum of squares accumulator
    localparam int PROD_W      = 82;   // product of both energies
    localparam int DSQ_W       = 83;   // squared dot magnitude
    localparam int WIDE_W      = 116;  // shared adder and root working registers
    localparam int FRAC_SHIFT  = 32;   // squared dot is scaled by 2^32
    localparam int ROOT_W      = 16;   // root search bits
    localparam int COS_W       = 17;   // Q1.15 plus headroom for +1.0
    localparam int CNT_W       = 6;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;

    localparam logic [COS_W-1:0] COS_ONE = 17'd32768;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_MULP,
        ST_MULD,
        ST_SQTRY,
        ST_SQUPD,
        ST_FIN,
        ST_DONE
    } cas_state_t;

endpackage

@@ rtl/core/cosine_anomaly_score.sv @@
// Streaming cosine similarity and anomaly score over element pairs
`timescale 1ns / 1ps
`include "cosine_anomaly_score_assert.svh"

// Channel   Dir  Width  Contents
// s_axis    in   32+1   tdata: sample_elem[15:0], reference_elem[31:16]; tlast: last_elem
// m_axis    out  40+1   tdata: cosine_value[16:0], anomaly_value[33:17]; tuser: zero_magnitude
//
// Pairs that are not last are taken in ST_IDLE and stream back to back. A last pair
// runs the energy product, the squared dot and the root search in turn, all on one
// shared 116-bit three-input adder; no pair is taken until the result is loaded.
// When either energy is zero the sequencer goes from ST_START straight to ST_DONE.
// rst_n clears the dot and energy accumulators, the sequencer and the output valid.
// The output register holds a result while m_axis_tready is low; pairs that are
// not last are still taken meanwhile while the sequencer is in ST_IDLE.

module cosine_anomaly_score
    import cas_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // sample_elem, reference_elem
    input  logic                   s_axis_tlast,   // last_elem
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // cosine_value, anomaly_value, zeros
    output logic                   m_axis_tuser    // zero_magnitude
);

    cas_state_t            state_reg, state_next;

    logic [DOT_W-1:0]      dot_reg, dot_next;
    logic [ENERGY_W-1:0]   se_reg, se_next;
    logic [ENERGY_W-1:0]   re_reg, re_next;

    logic [WIDE_W-1:0]     acc_reg, acc_next;
    logic [WIDE_W-1:0]     mcd_reg, mcd_next;
    logic [WIDE_W-1:0]     bk_reg, bk_next;
    logic [WIDE_W-1:0]     trial_reg, trial_next;
    logic [DOT_W-1:0]      mlr_reg, mlr_next;
    logic [PROD_W-1:0]     p_reg, p_next;
    logic [DSQ_W-1:0]      d2_reg, d2_next;
    logic [ROOT_W-1:0]     x_reg, x_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  neg_reg, neg_next;
    logic [COS_W-1:0]      res_cos_reg, res_cos_next;
    logic                  res_zero_reg, res_zero_next;

    logic                  out_valid_reg, out_valid_next;
    logic [COS_W-1:0]      out_cos_reg, out_cos_next;
    logic                  out_zero_reg, out_zero_next;

    logic signed [ELEM_W-1:0]   sample_s, reference_s;
    logic signed [2*ELEM_W-1:0] prod_sr, prod_ss, prod_rr;
    logic                  in_fire;
    logic [WIDE_W-1:0]     add_a, add_b, add_c, add_sum;
    logic                  root_fits;
    logic [DOT_W-1:0]      dot_mag;
    logic [COS_W-1:0]      x_inc, cos_mag;

    assign sample_s    = $signed(s_axis_tdata[ELEM_W-1:0]);
    assign reference_s = $signed(s_axis_tdata[2*ELEM_W-1:ELEM_W]);
    assign prod_sr     = sample_s * reference_s;
    assign prod_ss     = sample_s * sample_s;
    assign prod_rr     = reference_s * reference_s;
    assign in_fire     = s_axis_tvalid && s_axis_tready;

    assign dot_mag   = dot_reg[DOT_W-1] ? (~dot_reg + DOT_W'(1)) : dot_reg;
    assign root_fits = trial_reg <= {1'b0, d2_reg, {FRAC_SHIFT{1'b0}}};
    assign x_inc     = {1'b0, x_reg} + COS_W'(1);
    assign cos_mag   = {1'b0, x_inc[COS_W-1:1]};

    // Operand select for the shared adder
    always_comb
    begin
        add_a = '0;
        add_b = '0;
        add_c = '0;
        unique case (state_reg)
            ST_MULP, ST_MULD:
            begin
                add_a = acc_reg;
                add_b = mlr_reg[0] ? mcd_reg : '0;
            end
            ST_SQTRY:
            begin
                add_a = acc_reg;
                add_b = bk_reg;
                add_c = mcd_reg;
            end
            ST_SQUPD:
            begin
                add_a = bk_reg;
                add_b = mcd_reg << 1;
            end
            default:
            begin
                add_a = '0;
            end
        endcase
    end

    assign add_sum = add_a + add_b + add_c;

    // Sequencer: next state and datapath controls
    always_comb
    begin
        state_next    = state_reg;
        dot_next      = dot_reg;
        se_next       = se_reg;
        re_next       = re_reg;
        acc_next      = acc_reg;
        mcd_next      = mcd_reg;
        bk_next       = bk_reg;
        trial_next    = trial_reg;
        mlr_next      = mlr_reg;
        p_next        = p_reg;
        d2_next       = d2_reg;
        x_next        = x_reg;
        cnt_next      = cnt_reg;
        neg_next      = neg_reg;
        res_cos_next  = res_cos_reg;
        res_zero_next = res_zero_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_cos_next  = out_cos_reg;
        out_zero_next = out_zero_reg;
        s_axis_tready = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (in_fire)
                begin
                    dot_next = dot_reg + DOT_W'(prod_sr);
                    se_next  = se_reg + ENERGY_W'($unsigned(prod_ss));
                    re_next  = re_reg + ENERGY_W'($unsigned(prod_rr));
                    if (s_axis_tlast)
                    begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START:
            begin
                if (se_reg == '0 || re_reg == '0)
                begin
                    res_cos_next  = '0;
                    res_zero_next = 1'b1;
                    state_next    = ST_DONE;
                end
                else
                begin
                    neg_next   = dot_reg[DOT_W-1];
                    acc_next   = '0;
                    mcd_next   = WIDE_W'(se_reg);
                    mlr_next   = DOT_W'(re_reg);
                    cnt_next   = CNT_W'(ENERGY_W - 1);
                    state_next = ST_MULP;
                end
            end
            ST_MULP:
            begin
                acc_next = add_sum;
                mcd_next = mcd_reg << 1;
                mlr_next = mlr_reg >> 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    p_next     = add_sum[PROD_W-1:0];
                    acc_next   = '0;
                    mcd_next   = WIDE_W'(dot_mag);
                    mlr_next   = dot_mag;
                    cnt_next   = CNT_W'(DOT_W - 1);
                    state_next = ST_MULD;
                end
            end
            ST_MULD:
            begin
                acc_next = add_sum;
                mcd_next = mcd_reg << 1;
                mlr_next = mlr_reg >> 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    d2_next    = add_sum[DSQ_W-1:0];
                    acc_next   = '0;
                    bk_next    = '0;
                    mcd_next   = WIDE_W'(p_reg) << (2 * (ROOT_W - 1));
                    x_next     = '0;
                    cnt_next   = CNT_W'(ROOT_W - 1);
                    state_next = ST_SQTRY;
                end
            end
            ST_SQTRY:
            begin
                // trial = (x + 2^k)^2 * P from x^2*P, x*P*2^(k+1) and P*2^2k
                trial_next = add_sum;
                state_next = ST_SQUPD;
            end
            ST_SQUPD:
            begin
                if (root_fits)
                begin
                    acc_next = trial_reg;
                    bk_next  = add_sum >> 1;
                end
                else
                begin
                    bk_next = bk_reg >> 1;
                end
                x_next   = {x_reg[ROOT_W-2:0], root_fits};
                mcd_next = mcd_reg >> 2;
                if (cnt_reg == '0)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = ST_SQTRY;
                end
            end
            ST_FIN:
            begin
                // largest odd root candidate gives the rounded magnitude (x + 1) / 2
                res_cos_next  = neg_reg ? (~cos_mag + COS_W'(1)) : cos_mag;
                res_zero_next = 1'b0;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_cos_next   = res_cos_reg;
                    out_zero_next  = res_zero_reg;
                    dot_next       = '0;
                    se_next        = '0;
                    re_next        = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            dot_reg       <= '0;
            se_reg        <= '0;
            re_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            dot_reg       <= dot_next;
            se_reg        <= se_next;
            re_reg        <= re_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        mcd_reg      <= mcd_next;
        bk_reg       <= bk_next;
        trial_reg    <= trial_next;
        mlr_reg      <= mlr_next;
        p_reg        <= p_next;
        d2_reg       <= d2_next;
        x_reg        <= x_next;
        cnt_reg      <= cnt_next;
        neg_reg      <= neg_next;
        res_cos_reg  <= res_cos_next;
        res_zero_reg <= res_zero_next;
        out_cos_reg  <= out_cos_next;
        out_zero_reg <= out_zero_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - 2 * COS_W){1'b0}},
                            COS_ONE - out_cos_reg, out_cos_reg};
    assign m_axis_tuser  = out_zero_reg;

    `CAS_ASSERT_NEXT(a_last_blocks_input, s_axis_tvalid && s_axis_tready && s_axis_tlast,
        !s_axis_tready, "input still taken after a last item")
    `CAS_ASSERT_SAME(a_zero_gives_half, m_axis_tvalid && m_axis_tuser,
        m_axis_tdata[COS_W-1:0] == '0 && m_axis_tdata[2*COS_W-1:COS_W] == COS_ONE,
        "zero magnitude result is not cos 0, score one half")
    `CAS_ASSERT_SAME(a_score_matches_cos, m_axis_tvalid,
        m_axis_tdata[2*COS_W-1:COS_W] + m_axis_tdata[COS_W-1:0] == COS_ONE,
        "anomaly score and cosine disagree")
    `CAS_ASSERT_SAME(a_cos_in_range, m_axis_tvalid,
        $signed(m_axis_tdata[COS_W-1:0]) <= $signed(COS_ONE)
        && $signed(m_axis_tdata[COS_W-1:0]) >= -$signed(COS_ONE),
        "cosine outside [-1, 1]")
    `CAS_ASSERT_SAME(a_root_bound, state_reg == ST_SQTRY,
        acc_reg <= {1'b0, d2_reg, {FRAC_SHIFT{1'b0}}},
        "root search overshoots the squared dot bound")

endmodule

@@ tb/cosine_anomaly_score_tb.sv @@
// Self-checking testbench for the cosine anomaly score block
`timescale 1ns / 1ps

module cosine_anomaly_score_tb;
    import cas_pkg::*;

    localparam int ROW_COUNT    = 18;
    localparam int RANDOM_ITEMS = 1000;
    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic [COS_W-1:0] cosine;
        logic [COS_W-1:0] anomaly;
        logic             zero_mag;
    } score_t;

    typedef struct {
        int sample;
        int reference;
        int last;
        int reps;
        int pinned;
        int cosine;
        int anomaly;
        int zero_mag;
    } pair_row_t;

    typedef struct {
        bit     pinned;
        score_t score;
    } pinned_score_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // sample_elem, reference_elem
    logic                   s_axis_tlast;   // last_elem
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // cosine_value, anomaly_value, zeros
    logic                   m_axis_tuser;   // zero_magnitude

    logic [DOT_W-1:0]    dot_sum;
    logic [ENERGY_W-1:0] sample_sum;
    logic [ENERGY_W-1:0] reference_sum;

    score_t        expected_scores[$];
    pinned_score_t pinned_scores[$];
    int            score_mismatches;
    int            burst_left;
    int            idle_cycles;
    pair_row_t     pair_rows[ROW_COUNT];

    cosine_anomaly_score u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        score_mismatches++;
    endtask

    // Largest c with (2c-1)^2 * Es * Er <= 2^32 * dot^2, capped at +1.0
    function automatic int cosine_magnitude(input logic [DOT_W-1:0] mag,
                                            input logic [ENERGY_W-1:0] es,
                                            input logic [ENERGY_W-1:0] er);
        logic [127:0] prod;
        logic [127:0] bound;
        logic [127:0] odd;
        int           lo;
        int           hi;
        int           mid;
        prod  = 128'(es) * 128'(er);
        bound = (128'(mag) * 128'(mag)) << FRAC_SHIFT;
        lo    = 0;
        hi    = 32768;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            odd = 128'(2 * mid - 1);
            if (prod * odd * odd <= bound)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    task automatic accumulate_pair(input logic signed [ELEM_W-1:0] s,
                                   input logic signed [ELEM_W-1:0] r,
                                   input logic last);
        logic signed [31:0] sr;
        logic signed [31:0] ss;
        logic signed [31:0] rr;
        logic [DOT_W-1:0]   mag;
        int                 cosv;
        logic               zero_mag;
        score_t             score;
        pinned_score_t      pin;
        sr = s * r;
        ss = s * s;
        rr = r * r;
        dot_sum       = dot_sum + {{(DOT_W-32){sr[31]}}, sr};
        sample_sum    = sample_sum + ENERGY_W'(ss);
        reference_sum = reference_sum + ENERGY_W'(rr);
        if (last)
        begin
            zero_mag = 1'b0;
            if (sample_sum == '0 || reference_sum == '0)
            begin
                cosv     = 0;
                zero_mag = 1'b1;
            end
            else
            begin
                mag  = dot_sum[DOT_W-1] ? -dot_sum : dot_sum;
                cosv = cosine_magnitude(mag, sample_sum, reference_sum);
                if (dot_sum[DOT_W-1])
                    cosv = -cosv;
            end
            score = {COS_W'(cosv), COS_W'(32768 - cosv), zero_mag};
            // take the hand-written value where the row carries one
            if (pinned_scores.size() > 0)
            begin
                pin = pinned_scores.pop_front();
                if (pin.pinned)
                    score = pin.score;
            end
            expected_scores = {expected_scores, score};
            dot_sum       = '0;
            sample_sum    = '0;
            reference_sum = '0;
        end
    endtask

    task automatic push_pair(input logic [ELEM_W-1:0] s, input logic [ELEM_W-1:0] r,
                             input logic last, input bit pinned, input score_t pin_score);
        int            gap;
        pinned_score_t entry;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 60);
        end
        burst_left--;
        if (last)
        begin
            entry.pinned  = pinned;
            entry.score   = pin_score;
            pinned_scores = {pinned_scores, entry};
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r, s};
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    function automatic logic [ELEM_W-1:0] corner_elem();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h8001;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            4:       return 16'h0001;
            default: return 16'h7FFF;
        endcase
    endfunction

    // Score every accepted result, predict on every accepted item
    always @(posedge clk)
    begin
        score_t got;
        score_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata[COS_W-1:0], m_axis_tdata[2*COS_W-1:COS_W], m_axis_tuser};
                if (expected_scores.size() == 0)
                    flag_mismatch("result with nothing expected");
                else
                begin
                    want = expected_scores.pop_front();
                    if (got.cosine !== want.cosine)
                        flag_mismatch($sformatf("cosine_value got %0d want %0d",
                                                $signed(got.cosine), $signed(want.cosine)));
                    if (got.anomaly !== want.anomaly)
                        flag_mismatch($sformatf("anomaly_value got %0d want %0d",
                                                got.anomaly, want.anomaly));
                    if (got.zero_mag !== want.zero_mag)
                        flag_mismatch($sformatf("zero_magnitude got %0b want %0b",
                                                got.zero_mag, want.zero_mag));
                    if (m_axis_tdata[OUT_TDATA_W-1:2*COS_W] !== '0)
                        flag_mismatch("tdata padding not zero");
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                accumulate_pair(s_axis_tdata[ELEM_W-1:0], s_axis_tdata[2*ELEM_W-1:ELEM_W],
                                s_axis_tlast);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Receiver: stall patterns, plus two long hold-offs to back up the input
    initial
    begin
        int results_taken;
        int holds_done;
        int mode;
        int mode_left;
        logic ready;
        results_taken = 0;
        holds_done    = 0;
        mode          = 0;
        mode_left     = 0;
        m_axis_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                results_taken++;
            if (holds_done < 2 && results_taken == 25 + 70 * holds_done)
            begin
                holds_done++;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 150);
                end
                mode_left--;
                case (mode)
                    0:       ready = 1'b1;
                    1:       ready = 1'($urandom_range(0, 1));
                    2:       ready = ($urandom_range(0, 3) == 0);
                    default: ready = ((mode_left / 5) % 2 == 0);
                endcase
                m_axis_tready <= ready;
            end
        end
    end

    initial
    begin
        pair_row_t         row;
        score_t            pin_score;
        logic              is_last;
        logic [ELEM_W-1:0] s;
        logic [ELEM_W-1:0] r;
        int                random_sent;
        int                len;
        int                kind;
        int                pick;

        rst_n            = 1'b0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        s_axis_tlast     = 1'b0;
        dot_sum          = '0;
        sample_sum       = '0;
        reference_sum    = '0;
        score_mismatches = 0;
        burst_left       = 0;
        idle_cycles      = 0;

        // sample, reference, last, repeats, pinned, cosine, anomaly, zero magnitude
        pair_rows = '{
            '{0,      0,      1, 1,    1, 0,      32768, 1},  // both vectors zero
            '{4096,   0,      1, 1,    1, 0,      32768, 1},  // baseline zero
            '{0,      -4096,  1, 1,    1, 0,      32768, 1},  // sample zero
            '{32767,  32767,  1, 1,    1, 32768,  0,     0},
            '{-32768, -32768, 1, 1,    1, 32768,  0,     0},
            '{-32768, 32767,  1, 1,    1, -32768, 65536, 0},
            '{1,      -1,     1, 1,    1, -32768, 65536, 0},
            '{4096,   0,      0, 1,    0, 0,      0,     0},  // orthogonal pair
            '{0,      4096,   1, 1,    1, 0,      32768, 0},
            '{1000,   2000,   0, 1,    0, 0,      0,     0},
            '{-3000,  500,    0, 1,    0, 0,      0,     0},
            '{7,      -9,     1, 1,    0, 0,      0,     0},
            '{3,      4,      0, 1,    0, 0,      0,     0},
            '{4,      3,      1, 1,    0, 0,      0,     0},
            '{32767,  -1,     0, 1,    0, 0,      0,     0},
            '{-32768, 1,      1, 1,    0, 0,      0,     0},
            '{12345,  -23456, 0, 3,    0, 0,      0,     0},
            '{-1,     32767,  1, 1,    0, 0,      0,     0}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (pair_rows[i])
        begin
            row       = pair_rows[i];
            pin_score = {COS_W'(row.cosine), COS_W'(row.anomaly), row.zero_mag[0]};
            for (int k = 1; k <= row.reps; k++)
            begin
                is_last = (row.last != 0) && (k == row.reps);
                push_pair(ELEM_W'(row.sample), ELEM_W'(row.reference), is_last,
                          row.pinned != 0, pin_score);
            end
        end

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                len = $urandom_range(1, 8);
            else if (pick < 90)
                len = $urandom_range(9, 40);
            else
                len = $urandom_range(41, 160);
            kind = $urandom_range(0, 6);
            for (int k = 1; k <= len; k++)
            begin
                s = ELEM_W'($urandom);
                r = ELEM_W'($urandom);
                case (kind)
                    1:
                    begin
                        s = {{9{s[6]}}, s[6:0]};
                        r = {{9{r[6]}}, r[6:0]};
                    end
                    2:
                    begin
                        s = corner_elem();
                        r = corner_elem();
                    end
                    3:
                    begin
                        // near-parallel or near-opposite vectors
                        pick = $urandom_range(0, 2);
                        if (pick == 0)
                            r = s;
                        else if (pick == 1)
                            r = -s;
                        else
                            r = s + {{12{r[3]}}, r[3:0]};
                    end
                    4:
                    begin
                        if (len > 3)
                            s = '0;
                        else
                            r = '0;
                    end
                    5:
                        r = $signed(s) >>> $urandom_range(0, 4);
                    default:
                        ;
                endcase
                push_pair(s, r, k == len, 1'b0, '0);
                random_sent++;
            end
        end

        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        while (expected_scores.size() != 0 || pinned_scores.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (score_mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ cosine_anomaly_score.f @@
+incdir+rtl/core
rtl/core/cas_pkg.sv
rtl/core/cosine_anomaly_score.sv
tb/cosine_anomaly_score_tb.sv
